>>> rtl/core/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared widths, constants and types for the battery coulomb counter.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int unsigned CurW    = 16;  // current sample, signed mA
  localparam int unsigned CapW    = 20;  // capacity in milli-units
  localparam int unsigned ChgW    = CapW + 2;  // charge in quarter-milli-units
  localparam int unsigned SocW    = 7;   // state of charge in percent
  localparam int unsigned AccW    = 28;  // shared adder width, holds charge * 25
  localparam int unsigned StepW   = $clog2(SocW);
  localparam int unsigned OutW    = ((CapW + SocW + 7) / 8) * 8;
  localparam int unsigned OutPadW = OutW - CapW - SocW;

  localparam logic [CapW-1:0] CapReset = CapW'(10000);

  // Quotient bits come out most significant first.
  localparam logic [StepW-1:0] StepFirst = StepW'(SocW - 1);
  localparam logic [StepW-1:0] StepLast  = '0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC_PREV,
    ST_ACC_CUR,
    ST_CLAMP,
    ST_DIV_LOAD,
    ST_DIV,
    ST_FINISH
  } state_e;

  // Operand request to the shared adder.
  typedef struct packed {
    logic [AccW-1:0] a;
    logic [AccW-1:0] b;
    logic            sub;
  } alu_req_t;

endpackage

>>> rtl/core/bcc_alu.sv
// ----------------------------------------------------------------------------
// bcc_alu
// Shared add/subtract unit used for accumulation, clamping and division steps.
// ----------------------------------------------------------------------------
module bcc_alu
  import bcc_pkg::*;
(
  input  alu_req_t        req_i,
  output logic [AccW-1:0] res_o,
  output logic            neg_o
);

  logic [AccW-1:0] b_op;

  assign b_op  = req_i.sub ? ~req_i.b : req_i.b;
  assign res_o = req_i.a + b_op + AccW'(req_i.sub);
  assign neg_o = res_o[AccW-1];

endmodule

>>> rtl/core/battery_coulomb_counter_core.sv
// ----------------------------------------------------------------------------
// battery_coulomb_counter_core
// Trapezoidal coulomb counter with clamped charge and percent state of charge.
// ----------------------------------------------------------------------------
// Each current beat adds (previous + present) quarter-milli-units to the
// stored charge, clamps it to [0, 4 * capacity] and returns the charge in
// milli-units with the truncated percent of capacity. One shared 28-bit adder
// does the accumulation, the clamp compare and the division under a small
// sequencer: two adds, one clamp compare, a load state that forms charge * 25
// with a fixed shift-add, seven restoring division steps and a final state
// that writes the result register. The input takes a new beat only once the
// block is back in idle, after the previous result is written. A finished
// result waits in the output register while the next beat is taken; if that
// register is still full when the next result is done, the block holds until
// the downstream side takes the waiting beat. Writing the capacity refills the
// charge to full and clears the previous current; the write port is ready
// only while the block is idle.
module battery_coulomb_counter_core
  import bcc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // Capacity register write channel.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CapW-1:0]     cfg_data_i,
  // Current samples. tdata: [15:0] current_ma (signed).
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [CurW-1:0]     s_axis_tdata_i,
  // Results. tdata: [19:0] charge_milli, [26:20] soc_percent, [31:27] zero.
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutW-1:0]     m_axis_tdata_o
);

  state_e state_q, state_d;

  logic [CapW-1:0]        cap_q, cap_d;
  logic [ChgW-1:0]        charge_q, charge_d;
  logic signed [CurW-1:0] prev_q, prev_d;
  logic signed [CurW-1:0] cur_q, cur_d;
  logic [AccW-1:0]        acc_q, acc_d;
  logic [StepW-1:0]       step_q, step_d;
  logic [SocW-1:0]        quot_q, quot_d;
  logic                   m_valid_q, m_valid_d;
  logic [OutW-1:0]        m_data_q, m_data_d;

  alu_req_t        alu_req;
  logic [AccW-1:0] alu_res;
  logic            alu_neg;

  logic            out_free;
  logic            in_beat;
  logic            cfg_beat;
  logic [AccW-1:0] limit;
  logic [AccW-1:0] charge_ext;
  logic [SocW-1:0] soc;

  bcc_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res),
    .neg_o (alu_neg)
  );

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = (state_q == ST_IDLE);
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_beat        = cfg_valid_i && cfg_ready_o;
  assign limit           = AccW'({cap_q, 2'b00});
  assign charge_ext      = AccW'(charge_q);
  assign soc             = (cap_q == '0) ? '0 : quot_q;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_beat) state_d = ST_ACC_PREV;
      ST_ACC_PREV: state_d = ST_ACC_CUR;
      ST_ACC_CUR:  state_d = ST_CLAMP;
      ST_CLAMP:    state_d = ST_DIV_LOAD;
      ST_DIV_LOAD: state_d = ST_DIV;
      ST_DIV:      if (step_q == StepLast) state_d = ST_FINISH;
      ST_FINISH:   if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cap_d     = cap_q;
    charge_d  = charge_q;
    prev_d    = prev_q;
    cur_d     = cur_q;
    acc_d     = acc_q;
    step_d    = step_q;
    quot_d    = quot_q;
    m_data_d  = m_data_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    alu_req   = '{a: acc_q, b: '0, sub: 1'b0};

    unique case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          cur_d = s_axis_tdata_i;
        end
        if (cfg_beat) begin
          cap_d    = cfg_data_i;
          charge_d = {cfg_data_i, 2'b00};
          prev_d   = '0;
        end
      end
      ST_ACC_PREV: begin
        alu_req = '{a: charge_ext, b: AccW'(prev_q), sub: 1'b0};
        acc_d   = alu_res;
      end
      ST_ACC_CUR: begin
        alu_req = '{a: acc_q, b: AccW'(cur_q), sub: 1'b0};
        acc_d   = alu_res;
      end
      ST_CLAMP: begin
        // A negative difference means the sum ran past the capacity.
        alu_req = '{a: limit, b: acc_q, sub: 1'b1};
        if (alu_neg) begin
          charge_d = limit[ChgW-1:0];
        end else if (acc_q[AccW-1]) begin
          charge_d = '0;
        end else begin
          charge_d = acc_q[ChgW-1:0];
        end
        prev_d = cur_q;
      end
      ST_DIV_LOAD: begin
        // Dividend is charge * 25, which keeps the quotient below 128.
        acc_d  = (charge_ext << 4) + (charge_ext << 3) + charge_ext;
        step_d = StepFirst;
        quot_d = '0;
      end
      ST_DIV: begin
        alu_req = '{a: acc_q, b: AccW'(cap_q) << step_q, sub: 1'b1};
        if (!alu_neg) begin
          acc_d = alu_res;
        end
        quot_d = {quot_q[SocW-2:0], !alu_neg};
        step_d = step_q - StepW'(1);
      end
      ST_FINISH: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {OutPadW'(0), soc, charge_q[ChgW-1:2]};
        end
      end
      default: begin
        acc_d = acc_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cap_q     <= CapReset;
      charge_q  <= {CapReset, 2'b00};
      prev_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cap_q     <= cap_d;
      charge_q  <= charge_d;
      prev_q    <= prev_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    acc_q    <= acc_d;
    step_q   <= step_d;
    quot_q   <= quot_d;
    m_data_q <= m_data_d;
  end

endmodule
